// ===== rtl/tsd_pkg.sv =====
// Shared types and constants for the trie string dictionary.
// Used by the top level; depends on nothing else.
`default_nettype none

package tsd_pkg;

	// Default size of the node pool and of the letter alphabet.
	localparam int NODES_DEF    = 4096;
	localparam int ALPHABET_DEF = 26;

	// Operation codes carried by an input beat.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FIND   = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [4:0] letter;
		logic       has_letter;
		logic       last;
	} item_t;

	typedef struct packed {
		logic found;
		logic pool_full;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/tsd_ram.sv =====
// Generic synchronous RAM: one write port, one read port, registered read.
// Stands alone; the read data holds its value between reads.
`default_nettype none

module tsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/trie_string_dictionary.sv =====
// Trie string dictionary top level: walk control, node allocation and result register.
// Depends on tsd_pkg and on tsd_ram, which holds one row per node.
//
//   beat channel | valid        | stall        | payload
//   -------------+--------------+--------------+-----------------------------
//   item         | item_valid   | item_stall   | item   (tsd_pkg::item_t)
//   result       | result_valid | result_stall | result (tsd_pkg::result_t)
//
// A node row holds all child links of the node plus its key-end flag, so one
// read of the row RAM serves a letter step. A letter is read in IDLE and taken in
// EVAL, and passes CLEAR when it allocates a node (the new node's row is zeroed).
// A last beat with a letter then reads the final node's row in READ and, for an
// insert, updates it in EVAL. A last beat without a letter goes from IDLE to EVAL;
// any other beat without one is taken in IDLE alone. After reset INIT clears the
// root row before the first item beat. A result waits in its register while
// result_stall is high; the next key's letters are still taken, and only the next result waits for that register.
`default_nettype none

module trie_string_dictionary #(
	parameter int NODES    = tsd_pkg::NODES_DEF,
	parameter int ALPHABET = tsd_pkg::ALPHABET_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire tsd_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output tsd_pkg::result_t      result
);

	localparam int NODE_W = $clog2(NODES);
	localparam int LI_W   = $clog2(ALPHABET);
	localparam int ROW_W  = ALPHABET * NODE_W + 1;

	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_CLEAR = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;

	logic [2:0]        state_q;
	logic              op_q;
	logic [LI_W-1:0]   ch_q;
	logic              has_q;
	logic              last_q;
	logic              fin_q;
	logic [NODE_W-1:0] walk_node_q;
	logic [NODE_W-1:0] nodes_used_q;
	logic              missed_q;
	logic              overflow_q;
	logic              res_valid_q;
	tsd_pkg::result_t  res_q;

	logic              ram_we;
	logic [NODE_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [ROW_W-1:0]  ram_rdata;

	logic [ALPHABET-1:0][NODE_W-1:0] row_links;
	logic [ALPHABET-1:0][NODE_W-1:0] new_links;
	logic              row_flag;
	logic [NODE_W-1:0] child;
	logic [NODE_W-1:0] new_node;
	logic [31:0]       letter_ext;
	logic [LI_W-1:0]   letter_idx;
	logic              accept;
	logic              dead;
	logic              res_free;
	logic              res_load;
	logic              step;
	logic              alloc;
	logic              pool_out;

	tsd_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NODES)
	) u_rows (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (walk_node_q),
		.rdata (ram_rdata)
	);

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign res_free     = !res_valid_q || !result_stall;
	assign res_load     = (state_q == ST_EVAL) && fin_q && res_free;

	// Letters beyond the alphabet fold onto its last letter.
	assign letter_ext = 32'(item.letter);
	assign letter_idx = (letter_ext >= 32'(ALPHABET)) ? LI_W'(ALPHABET - 1)
	                                                  : LI_W'(letter_ext);

	assign row_links = ram_rdata[ROW_W-1:1];
	assign row_flag  = ram_rdata[0];
	assign child     = row_links[ch_q];
	assign new_node  = nodes_used_q + NODE_W'(1);
	assign dead      = missed_q || overflow_q;

	// A letter step in EVAL: only a live walk with a letter moves.
	assign step     = (state_q == ST_EVAL) && !fin_q && has_q && !dead;
	assign pool_out = (nodes_used_q == NODE_W'(NODES - 1));
	assign alloc    = step && (child == '0) && (op_q == tsd_pkg::OP_INSERT) && !pool_out;

	always_comb begin
		new_links         = row_links;
		new_links[ch_q]   = new_node;
		ram_re            = 1'b0;
		ram_we            = 1'b0;
		ram_waddr         = walk_node_q;
		ram_wdata         = '0;
		case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
			end
			ST_IDLE: begin
				ram_re = accept && (item.has_letter || item.last);
			end
			ST_EVAL: begin
				if (alloc) begin
					ram_we    = 1'b1;
					ram_wdata = {new_links, row_flag};
				end else if (fin_q && res_free && !dead && op_q == tsd_pkg::OP_INSERT) begin
					ram_we    = 1'b1;
					ram_wdata = {row_links, 1'b1};
				end
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			fin_q        <= 1'b0;
			walk_node_q  <= '0;
			nodes_used_q <= '0;
			missed_q     <= 1'b0;
			overflow_q   <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (item.has_letter) begin
							fin_q   <= 1'b0;
							state_q <= ST_EVAL;
						end else if (item.last) begin
							fin_q   <= 1'b1;
							state_q <= ST_EVAL;
						end
					end
				end
				ST_EVAL: begin
					if (!fin_q) begin
						if (step) begin
							if (child != '0) begin
								walk_node_q <= child;
							end else if (op_q == tsd_pkg::OP_FIND) begin
								missed_q <= 1'b1;
							end else if (pool_out) begin
								overflow_q <= 1'b1;
							end else begin
								nodes_used_q <= new_node;
								walk_node_q  <= new_node;
							end
						end
						if (alloc) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= last_q ? ST_READ : ST_IDLE;
						end
					end else if (res_free) begin
						walk_node_q <= '0;
						missed_q    <= 1'b0;
						overflow_q  <= 1'b0;
						fin_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					state_q <= last_q ? ST_READ : ST_IDLE;
				end
				ST_READ: begin
					fin_q   <= 1'b1;
					state_q <= ST_EVAL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the item fields of the beat in work and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= item.operation;
			ch_q   <= letter_idx;
			has_q  <= item.has_letter;
			last_q <= item.last;
		end
		if (res_load) begin
			res_q.found     <= !dead && ((op_q == tsd_pkg::OP_INSERT) || row_flag);
			res_q.pool_full <= overflow_q;
		end
	end

endmodule

`default_nettype wire
